// ----- hdl/rtped_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and status codes for the RTP header parser with the ED-137 extension.
// Every other file of the block depends on this package.
package rtped_pkg;

	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 16;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] REG_PROFILE_MAIN = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PROFILE_ALT  = 8'd1;

	localparam logic [1:0]  HDR_VERSION   = 2'd2;
	localparam logic [6:0]  HDR_LEN       = 7'd12;
	localparam logic [6:0]  EXT_HDR_BYTES = 7'd4;
	localparam logic [15:0] COUNT_LIMIT   = 16'hFFFF;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_SHORT      = 3'd1;
	localparam logic [2:0] ST_BAD_VER    = 3'd2;
	localparam logic [2:0] ST_EXT_HDR    = 3'd3;
	localparam logic [2:0] ST_EXT_BODY   = 3'd4;
	localparam logic [2:0] ST_PAD_OVER   = 3'd5;
	localparam logic [2:0] ST_OVERSIZE   = 3'd6;

	// Summary of one packet, handed from the capture side to the evaluation side.
	typedef struct packed {
		logic        oversize;
		logic [15:0] len;
		logic [7:0]  first;
		logic [15:0] seq;
		logic [31:0] stamp;
		logic [15:0] words;
		logic [8:0]  sig_top;
		logic [7:0]  last_data;
		logic        profile_hit;
	} rec_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] seq_number;
		logic [31:0] time_stamp;
		logic [15:0] payload_offset;
		logic [15:0] payload_length;
		logic [2:0]  ptt_kind;
		logic        squelch;
		logic [3:0]  ptt_ident;
		logic        sct_flag;
	} res_t;

endpackage

// ----- hdl/rtped_if.sv -----
`timescale 1ns / 1ps
// Handshake channels of the parser: packet bytes in, results out, register writes.
// Depends on rtped_pkg for the widths.
interface rtped_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, data_byte, last_byte, input ready);
	modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface rtped_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] seq_number;
	logic [31:0] time_stamp;
	logic [15:0] payload_offset;
	logic [15:0] payload_length;
	logic [2:0]  ptt_kind;
	logic        squelch;
	logic [3:0]  ptt_ident;
	logic        sct_flag;
	modport source (output valid, status, seq_number, time_stamp, payload_offset,
		payload_length, ptt_kind, squelch, ptt_ident, sct_flag, input ready);
	modport sink (input valid, status, seq_number, time_stamp, payload_offset,
		payload_length, ptt_kind, squelch, ptt_ident, sct_flag, output ready);
endinterface

interface rtped_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [rtped_pkg::CFG_IDX_W-1:0]  index;
	logic [rtped_pkg::CFG_DATA_W-1:0] wdata;
	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

// ----- hdl/rtped_front.sv -----
`timescale 1ns / 1ps
// Capture side: counts packet bytes, captures header and extension fields, holds the profile
// registers and hands a packet summary to the queue on the last byte. Depends on rtped_pkg.
module rtped_front (
	input  logic            clk,
	input  logic            arst_n,
	rtped_byte_if.sink      pkt_in,
	rtped_cfg_if.sink       cfg,
	input  logic            q_full,
	output logic            push,
	output rtped_pkg::rec_t push_rec
);

	logic [15:0] byte_count_q;
	logic [7:0]  first_q;
	logic [15:0] seq_q;
	logic [31:0] stamp_q;
	logic [15:0] profile_q;
	logic [15:0] words_q;
	logic [31:0] signal_q;
	logic        oversize_q;
	logic [15:0] prof_main_q;
	logic [15:0] prof_alt_q;

	logic        take;
	logic        do_cap;
	logic        oversize_n;
	logic [15:0] ext_pos;
	logic [15:0] words_pos;
	logic [15:0] sig_pos;
	logic [15:0] count_n;
	logic [7:0]  first_n;
	logic [15:0] seq_n;
	logic [31:0] stamp_n;
	logic [15:0] profile_n;
	logic [15:0] words_n;
	logic [31:0] signal_n;

	assign pkt_in.ready = !q_full;
	assign cfg.ready    = 1'b1;
	assign take         = pkt_in.valid && pkt_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prof_main_q <= '0;
			prof_alt_q  <= '0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				rtped_pkg::REG_PROFILE_MAIN: prof_main_q <= cfg.wdata;
				rtped_pkg::REG_PROFILE_ALT:  prof_alt_q  <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// The extension starts on a word boundary, so the byte pairs and quads compare on upper bits.
	always_comb begin
		ext_pos    = {9'd0, rtped_pkg::HDR_LEN + {1'b0, first_q[3:0], 2'b00}};
		words_pos  = ext_pos + 16'd2;
		sig_pos    = ext_pos + 16'd4;
		oversize_n = oversize_q || (byte_count_q == rtped_pkg::COUNT_LIMIT);
		do_cap     = !oversize_n;
		count_n    = oversize_n ? byte_count_q : byte_count_q + 16'd1;
		first_n    = first_q;
		seq_n      = seq_q;
		stamp_n    = stamp_q;
		profile_n  = profile_q;
		words_n    = words_q;
		signal_n   = signal_q;
		if (do_cap) begin
			if (byte_count_q == 16'd0)
				first_n = pkt_in.data_byte;
			if (byte_count_q[15:1] == 15'd1)
				seq_n = {seq_q[7:0], pkt_in.data_byte};
			if (byte_count_q[15:2] == 14'd1)
				stamp_n = {stamp_q[23:0], pkt_in.data_byte};
			if (byte_count_q[15:1] == ext_pos[15:1])
				profile_n = {profile_q[7:0], pkt_in.data_byte};
			if (byte_count_q[15:1] == words_pos[15:1])
				words_n = {words_q[7:0], pkt_in.data_byte};
			if (byte_count_q[15:2] == sig_pos[15:2])
				signal_n = {signal_q[23:0], pkt_in.data_byte};
		end
	end

	always_comb begin
		push_rec.oversize    = oversize_n;
		push_rec.len         = byte_count_q + 16'd1;
		push_rec.first       = first_n;
		push_rec.seq         = seq_n;
		push_rec.stamp       = stamp_n;
		push_rec.words       = words_n;
		push_rec.sig_top     = signal_n[31:23];
		push_rec.last_data   = pkt_in.data_byte;
		push_rec.profile_hit = (profile_n == prof_main_q) || (profile_n == prof_alt_q);
	end

	assign push = take && pkt_in.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			first_q      <= '0;
			seq_q        <= '0;
			stamp_q      <= '0;
			profile_q    <= '0;
			words_q      <= '0;
			signal_q     <= '0;
			oversize_q   <= 1'b0;
		end else if (take) begin
			if (pkt_in.last_byte) begin
				byte_count_q <= '0;
				first_q      <= '0;
				seq_q        <= '0;
				stamp_q      <= '0;
				profile_q    <= '0;
				words_q      <= '0;
				signal_q     <= '0;
				oversize_q   <= 1'b0;
			end else begin
				byte_count_q <= count_n;
				first_q      <= first_n;
				seq_q        <= seq_n;
				stamp_q      <= stamp_n;
				profile_q    <= profile_n;
				words_q      <= words_n;
				signal_q     <= signal_n;
				oversize_q   <= oversize_n;
			end
		end
	end

	a_oversize_holds_count: assert property (@(posedge clk) disable iff (!arst_n)
		oversize_q |-> byte_count_q == rtped_pkg::COUNT_LIMIT)
		else $error("oversize set while the byte count is not saturated");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (byte_count_q == 16'd0) && !oversize_q && (first_q == 8'd0))
		else $error("packet state not cleared after the last byte");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("packet summary pushed into a full queue");

endmodule

// ----- hdl/rtped_queue.sv -----
`timescale 1ns / 1ps
// Short register queue of packet summaries between the capture and evaluation sides.
// Depends on rtped_pkg for the summary type.
module rtped_queue #(
	parameter int DEPTH = rtped_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rtped_pkg::rec_t push_rec,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output rtped_pkg::rec_t head_rec
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rtped_pkg::rec_t entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full       = count_q == CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_rec   = entries_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (!push && do_pop)
				count_q <= count_q - 1'b1;
		end
	end

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill count beyond its depth");

	a_empty_pointers_meet: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers differ while the queue is empty");

endmodule

// ----- hdl/rtped_back.sv -----
`timescale 1ns / 1ps
// Evaluation side: works out status, payload offset and length and the signalling fields
// in two stages and an output register. Depends on rtped_pkg.
module rtped_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  rtped_pkg::rec_t head_rec,
	output logic            pop,
	rtped_result_if.source  res_out
);

	typedef struct packed {
		rtped_pkg::rec_t rec;
		logic [6:0]      off_hdr;
		logic [18:0]     ext_end;
		logic            hdr_cut;
		logic [7:0]      pad;
	} s1_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        sig_ok;
		logic [15:0] seq;
		logic [31:0] stamp;
		logic [15:0] len;
		logic [18:0] off;
		logic [19:0] off_pad;
		logic [8:0]  sig_top;
	} s2_t;

	logic            adv;
	logic            s1_valid_s1;
	logic            s2_valid_s2;
	logic            out_valid_q;
	s1_t             st_s1;
	s2_t             st_s2;
	rtped_pkg::res_t res_q;
	s1_t             s1_n;
	s2_t             s2_n;
	rtped_pkg::res_t res_n;
	logic            x_bit;
	logic            body_cut;
	logic [20:0]     diff;

	assign adv = !out_valid_q || res_out.ready;
	assign pop = adv && head_valid;

	always_comb begin
		s1_n.rec     = head_rec;
		s1_n.off_hdr = rtped_pkg::HDR_LEN + {1'b0, head_rec.first[3:0], 2'b00};
		s1_n.ext_end = {12'd0, s1_n.off_hdr + rtped_pkg::EXT_HDR_BYTES}
			+ {1'b0, head_rec.words, 2'b00};
		s1_n.hdr_cut = head_rec.len < {9'd0, s1_n.off_hdr + rtped_pkg::EXT_HDR_BYTES};
		s1_n.pad     = head_rec.first[5] ? head_rec.last_data : 8'd0;
	end

	always_comb begin
		x_bit    = st_s1.rec.first[4];
		body_cut = {3'd0, st_s1.rec.len} < st_s1.ext_end;
		if (st_s1.rec.oversize)
			s2_n.status = rtped_pkg::ST_OVERSIZE;
		else if (st_s1.rec.len < {9'd0, rtped_pkg::HDR_LEN})
			s2_n.status = rtped_pkg::ST_SHORT;
		else if (st_s1.rec.first[7:6] != rtped_pkg::HDR_VERSION)
			s2_n.status = rtped_pkg::ST_BAD_VER;
		else if (x_bit && st_s1.hdr_cut)
			s2_n.status = rtped_pkg::ST_EXT_HDR;
		else if (x_bit && body_cut)
			s2_n.status = rtped_pkg::ST_EXT_BODY;
		else
			s2_n.status = rtped_pkg::ST_OK;
		s2_n.sig_ok  = x_bit && st_s1.rec.profile_hit && (st_s1.rec.words != 16'd0);
		s2_n.seq     = st_s1.rec.seq;
		s2_n.stamp   = st_s1.rec.stamp;
		s2_n.len     = st_s1.rec.len;
		s2_n.off     = x_bit ? st_s1.ext_end : {12'd0, st_s1.off_hdr};
		s2_n.off_pad = {1'b0, s2_n.off} + {12'd0, st_s1.pad};
		s2_n.sig_top = st_s1.rec.sig_top;
	end

	// A borrow out of the length minus offset and padding marks a padding overrun.
	always_comb begin
		diff                 = {5'd0, st_s2.len} - {1'b0, st_s2.off_pad};
		res_n.status         = st_s2.status;
		res_n.seq_number     = st_s2.seq;
		res_n.time_stamp     = st_s2.stamp;
		res_n.payload_offset = '0;
		res_n.payload_length = '0;
		res_n.ptt_kind       = '0;
		res_n.squelch        = 1'b0;
		res_n.ptt_ident      = '0;
		res_n.sct_flag       = 1'b0;
		if (st_s2.status == rtped_pkg::ST_OK) begin
			if (diff[20]) begin
				res_n.status = rtped_pkg::ST_PAD_OVER;
			end else begin
				res_n.payload_offset = st_s2.off[15:0];
				res_n.payload_length = diff[15:0];
				if (st_s2.sig_ok) begin
					res_n.ptt_kind  = st_s2.sig_top[8:6];
					res_n.squelch   = st_s2.sig_top[5];
					res_n.ptt_ident = st_s2.sig_top[4:1];
					res_n.sct_flag  = st_s2.sig_top[0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			s2_valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid_s1 <= head_valid;
			s2_valid_s2 <= s1_valid_s1;
			out_valid_q <= s2_valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1 <= s1_n;
			st_s2 <= s2_n;
			res_q <= res_n;
		end
	end

	assign res_out.valid          = out_valid_q;
	assign res_out.status         = res_q.status;
	assign res_out.seq_number     = res_q.seq_number;
	assign res_out.time_stamp     = res_q.time_stamp;
	assign res_out.payload_offset = res_q.payload_offset;
	assign res_out.payload_length = res_q.payload_length;
	assign res_out.ptt_kind       = res_q.ptt_kind;
	assign res_out.squelch        = res_q.squelch;
	assign res_out.ptt_ident      = res_q.ptt_ident;
	assign res_out.sct_flag       = res_q.sct_flag;

	a_error_clears_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (res_q.status != rtped_pkg::ST_OK))
		|-> (res_q.payload_offset == 16'd0) && (res_q.payload_length == 16'd0)
			&& (res_q.ptt_kind == 3'd0) && !res_q.squelch && (res_q.ptt_ident == 4'd0)
			&& !res_q.sct_flag)
		else $error("payload or signalling fields set on a failed packet");

	a_ok_offset_past_header: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (res_q.status == rtped_pkg::ST_OK))
		|-> res_q.payload_offset >= {9'd0, rtped_pkg::HDR_LEN})
		else $error("payload offset inside the fixed header");

	a_stage_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_valid_s2 && !adv) |=> s2_valid_s2 && $stable(st_s2))
		else $error("second stage lost its item during an output stall");

endmodule

// ----- hdl/rtp_ed137_header_parser.sv -----
`timescale 1ns / 1ps
// Top level of the RTP header parser with ED-137 signalling extension.
// Depends on rtped_pkg, the channel interfaces, rtped_front, rtped_queue and rtped_back.
//
// The parser takes one packet byte per clock cycle while the queue is not full, with no gaps needed
// between packets, and gives one result for each packet: the capture logic hands a packet summary
// to a short queue, and a two-stage evaluation pipeline with an output register works out the
// status, payload offset and length and the signalling fields.
// Bytes are refused only while the queue is full, which happens when results are not taken for
// several packets in a row. Profile registers are written through the configuration channel,
// which is always ready, and should be changed only while no packet is in flight.
module rtp_ed137_header_parser #(
	parameter int QUEUE_DEPTH = rtped_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	rtped_cfg_if.sink      cfg,
	rtped_byte_if.sink     pkt_in,
	rtped_result_if.source res_out
);

	logic            q_full;
	logic            push;
	rtped_pkg::rec_t push_rec;
	logic            pop;
	logic            head_valid;
	rtped_pkg::rec_t head_rec;

	rtped_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.pkt_in   (pkt_in),
		.cfg      (cfg),
		.q_full   (q_full),
		.push     (push),
		.push_rec (push_rec)
	);

	rtped_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_rec   (head_rec)
	);

	rtped_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_rec   (head_rec),
		.pop        (pop),
		.res_out    (res_out)
	);

endmodule
